FILE: design/m3i_pkg.sv
// m3i_pkg: shared types, widths and tables of the 3x3 matrix inverse core.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package m3i_pkg;

    localparam int IN_W      = 16;
    localparam int PROD_W    = 32;
    localparam int COF_W     = 33;
    localparam int DTERM_W   = 49;
    localparam int DET_W     = 52;
    localparam int NUM_SHIFT = 24;
    localparam int MAG_W     = 33;
    localparam int REM_W     = MAG_W + NUM_SHIFT;
    localparam int QUO_W     = 32;
    localparam int CMP_W     = DET_W + QUO_W;
    localparam int OUT_W     = 32;
    localparam int N_ENT     = 9;

    localparam int COF_STAGES = 4;
    localparam int DIV_STAGES = QUO_W + 2;
    localparam int PIPE_DEPTH = COF_STAGES + DIV_STAGES;

    // cofactors that carry a minus sign
    localparam logic [N_ENT-1:0] COF_NEG = 9'b010101010;

    // output entry (i,j) takes cofactor (j,i)
    localparam int TRANSPOSE [N_ENT] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [IN_W-1:0] a00;
        logic signed [IN_W-1:0] a01;
        logic signed [IN_W-1:0] a02;
        logic signed [IN_W-1:0] a10;
        logic signed [IN_W-1:0] a11;
        logic signed [IN_W-1:0] a12;
        logic signed [IN_W-1:0] a20;
        logic signed [IN_W-1:0] a21;
        logic signed [IN_W-1:0] a22;
    } mat_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] r00;
        logic signed [OUT_W-1:0] r01;
        logic signed [OUT_W-1:0] r02;
        logic signed [OUT_W-1:0] r10;
        logic signed [OUT_W-1:0] r11;
        logic signed [OUT_W-1:0] r12;
        logic signed [OUT_W-1:0] r20;
        logic signed [OUT_W-1:0] r21;
        logic signed [OUT_W-1:0] r22;
        logic                    singular;
    } inv_word_t;

    typedef struct packed {
        logic [N_ENT-1:0][COF_W-1:0] cof;
        logic [DET_W-1:0]            det;
    } cof_word_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [N_ENT-1:0] lane;
        logic [DET_W-1:0]      dmag;
        logic                  sing;
    } div_stage_t;

endpackage

`default_nettype wire

FILE: design/matrix3_inverse_core.sv
// matrix3_inverse_core: top level of the pipelined 3x3 matrix inverse.
// Depends on m3i_pkg, m3i_cofactor and m3i_divider.
//
// Takes one Q8.8 matrix word per cycle while mat_stall is low and returns its
// inverse as nine Q16.16 entries, truncated toward zero and saturated to 32 bits;
// a zero determinant sets singular and zeroes all entries. Four stages form the
// cofactors and determinant, then the nine-lane divider spends one stage on
// magnitudes, one stage per quotient bit (32) and one on sign and saturation.
// Every stage holds a valid bit and advances when the one ahead is empty or
// moving, so bubbles close up under inv_stall and up to 38 words are in flight.
`default_nettype none

module matrix3_inverse_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               mat_valid,
    output logic                    mat_stall,
    input  wire m3i_pkg::mat_word_t mat,
    output logic                    inv_valid,
    input  wire logic               inv_stall,
    output m3i_pkg::inv_word_t      inv
);

    logic               cof_valid;
    logic               cof_stall;
    m3i_pkg::cof_word_t cof;

    m3i_cofactor u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat       (mat),
        .cof_valid (cof_valid),
        .cof_stall (cof_stall),
        .cof       (cof)
    );

    m3i_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .cof_valid (cof_valid),
        .cof_stall (cof_stall),
        .cof       (cof),
        .inv_valid (inv_valid),
        .inv_stall (inv_stall),
        .inv       (inv)
    );

endmodule

`default_nettype wire

FILE: design/m3i_cofactor.sv
// m3i_cofactor: four-stage pipeline forming the nine cofactors and the determinant.
// Depends on m3i_pkg.
`default_nettype none

module m3i_cofactor (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               mat_valid,
    output logic                    mat_stall,
    input  wire m3i_pkg::mat_word_t mat,
    output logic                    cof_valid,
    input  wire logic               cof_stall,
    output m3i_pkg::cof_word_t      cof
);

    localparam int IN_W    = m3i_pkg::IN_W;
    localparam int PROD_W  = m3i_pkg::PROD_W;
    localparam int COF_W   = m3i_pkg::COF_W;
    localparam int DTERM_W = m3i_pkg::DTERM_W;
    localparam int DET_W   = m3i_pkg::DET_W;
    localparam int N_ENT   = m3i_pkg::N_ENT;
    localparam int NS      = m3i_pkg::COF_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   rdy;

    logic signed [PROD_W-1:0] pa_reg [N_ENT];
    logic signed [PROD_W-1:0] pb_reg [N_ENT];
    logic signed [PROD_W-1:0] pa_next [N_ENT];
    logic signed [PROD_W-1:0] pb_next [N_ENT];
    logic signed [IN_W-1:0]   e1_reg [3];
    logic signed [IN_W-1:0]   e2_reg [3];
    logic signed [COF_W-1:0]  c2_reg [N_ENT];
    logic signed [COF_W-1:0]  c3_reg [N_ENT];
    logic signed [COF_W-1:0]  c4_reg [N_ENT];
    logic signed [DTERM_W-1:0] t3_reg [3];
    logic signed [DET_W-1:0]  det4_reg;

    always_comb
    begin
        rdy[NS] = !cof_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign mat_stall = !rdy[0];
    assign cof_valid = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= mat_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // 2x2 minors as pa - pb
    always_comb
    begin
        pa_next[0] = mat.a11 * mat.a22;  pb_next[0] = mat.a21 * mat.a12;
        pa_next[1] = mat.a10 * mat.a22;  pb_next[1] = mat.a20 * mat.a12;
        pa_next[2] = mat.a10 * mat.a21;  pb_next[2] = mat.a20 * mat.a11;
        pa_next[3] = mat.a01 * mat.a22;  pb_next[3] = mat.a21 * mat.a02;
        pa_next[4] = mat.a00 * mat.a22;  pb_next[4] = mat.a20 * mat.a02;
        pa_next[5] = mat.a00 * mat.a21;  pb_next[5] = mat.a20 * mat.a01;
        pa_next[6] = mat.a01 * mat.a12;  pb_next[6] = mat.a11 * mat.a02;
        pa_next[7] = mat.a00 * mat.a12;  pb_next[7] = mat.a10 * mat.a02;
        pa_next[8] = mat.a00 * mat.a11;  pb_next[8] = mat.a10 * mat.a01;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && mat_valid)
        begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            e1_reg[0] <= mat.a00;
            e1_reg[1] <= mat.a01;
            e1_reg[2] <= mat.a02;
        end
        if (rdy[1] && valid_reg[0])
        begin
            for (int k = 0; k < N_ENT; k++)
            begin
                if (m3i_pkg::COF_NEG[k])
                begin
                    c2_reg[k] <= COF_W'(pb_reg[k]) - COF_W'(pa_reg[k]);
                end
                else
                begin
                    c2_reg[k] <= COF_W'(pa_reg[k]) - COF_W'(pb_reg[k]);
                end
            end
            e2_reg <= e1_reg;
        end
        if (rdy[2] && valid_reg[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                t3_reg[k] <= DTERM_W'(e2_reg[k]) * DTERM_W'(c2_reg[k]);
            end
            c3_reg <= c2_reg;
        end
        if (rdy[3] && valid_reg[2])
        begin
            det4_reg <= DET_W'(t3_reg[0]) + DET_W'(t3_reg[1]) + DET_W'(t3_reg[2]);
            c4_reg   <= c3_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < N_ENT; k++)
        begin
            cof.cof[k] = c4_reg[k];
        end
        cof.det = det4_reg;
    end

endmodule

`default_nettype wire

FILE: design/m3i_divider.sv
// m3i_divider: nine-lane pipelined restoring divider, one quotient bit per stage,
// with sign, saturation and singular handling. Depends on m3i_pkg.
`default_nettype none

module m3i_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cof_valid,
    output logic                    cof_stall,
    input  wire m3i_pkg::cof_word_t cof,
    output logic                    inv_valid,
    input  wire logic               inv_stall,
    output m3i_pkg::inv_word_t      inv
);

    localparam int COF_W = m3i_pkg::COF_W;
    localparam int DET_W = m3i_pkg::DET_W;
    localparam int MAG_W = m3i_pkg::MAG_W;
    localparam int REM_W = m3i_pkg::REM_W;
    localparam int QUO_W = m3i_pkg::QUO_W;
    localparam int CMP_W = m3i_pkg::CMP_W;
    localparam int OUT_W = m3i_pkg::OUT_W;
    localparam int N_ENT = m3i_pkg::N_ENT;
    localparam int NSTG  = QUO_W + 1;

    logic [NSTG:0]   valid_reg;
    logic [NSTG+1:0] rdy;

    m3i_pkg::div_stage_t stg_reg [NSTG];
    m3i_pkg::div_stage_t prep_next;
    logic [OUT_W-1:0]    res_next [N_ENT];
    logic [OUT_W-1:0]    res_reg [N_ENT];
    logic                sing_reg;

    always_comb
    begin
        rdy[NSTG+1] = !inv_stall;
        for (int k = NSTG; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign cof_stall = !rdy[0];
    assign inv_valid = valid_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= cof_valid;
            end
            for (int k = 1; k <= NSTG; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // magnitudes, signs and the overflow test
    always_comb
    begin
        logic signed [DET_W-1:0] d;
        logic [DET_W-1:0]        dmag;
        logic signed [COF_W-1:0] c;
        logic [MAG_W-1:0]        mag;
        logic [REM_W-1:0]        num;
        d    = $signed(cof.det);
        dmag = d[DET_W-1] ? DET_W'(-d) : DET_W'(d);
        prep_next.dmag = dmag;
        prep_next.sing = (d == '0);
        for (int l = 0; l < N_ENT; l++)
        begin
            c   = $signed(cof.cof[m3i_pkg::TRANSPOSE[l]]);
            mag = c[COF_W-1] ? MAG_W'(-c) : MAG_W'(c);
            num = {mag, {m3i_pkg::NUM_SHIFT{1'b0}}};
            prep_next.lane[l].rem = num;
            prep_next.lane[l].quo = '0;
            prep_next.lane[l].neg = c[COF_W-1] ^ d[DET_W-1];
            prep_next.lane[l].ovf = CMP_W'(num) >= {dmag, {QUO_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && cof_valid)
        begin
            stg_reg[0] <= prep_next;
        end
    end

    for (genvar s = 1; s < NSTG; s++)
    begin : g_step
        localparam int K = QUO_W - s;
        m3i_pkg::div_stage_t step_next;

        always_comb
        begin
            logic [CMP_W-1:0] dsh;
            logic [CMP_W-1:0] diff;
            logic             ge;
            step_next = stg_reg[s-1];
            dsh = CMP_W'(stg_reg[s-1].dmag) << K;
            for (int l = 0; l < N_ENT; l++)
            begin
                ge   = CMP_W'(stg_reg[s-1].lane[l].rem) >= dsh;
                diff = CMP_W'(stg_reg[s-1].lane[l].rem) - dsh;
                step_next.lane[l].rem = ge ? diff[REM_W-1:0] : stg_reg[s-1].lane[l].rem;
                step_next.lane[l].quo[K] = ge;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && valid_reg[s-1])
            begin
                stg_reg[s] <= step_next;
            end
        end
    end

    always_comb
    begin
        logic [QUO_W-1:0] q;
        for (int l = 0; l < N_ENT; l++)
        begin
            q = stg_reg[NSTG-1].lane[l].quo;
            if (stg_reg[NSTG-1].sing)
            begin
                res_next[l] = '0;
            end
            else if (stg_reg[NSTG-1].lane[l].ovf)
            begin
                res_next[l] = stg_reg[NSTG-1].lane[l].neg ? m3i_pkg::SAT_MIN
                                                          : m3i_pkg::SAT_MAX;
            end
            else if (stg_reg[NSTG-1].lane[l].neg)
            begin
                res_next[l] = q[QUO_W-1] ? m3i_pkg::SAT_MIN : OUT_W'(-q);
            end
            else
            begin
                res_next[l] = q[QUO_W-1] ? m3i_pkg::SAT_MAX : OUT_W'(q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NSTG] && valid_reg[NSTG-1])
        begin
            res_reg  <= res_next;
            sing_reg <= stg_reg[NSTG-1].sing;
        end
    end

    always_comb
    begin
        inv.r00      = res_reg[0];
        inv.r01      = res_reg[1];
        inv.r02      = res_reg[2];
        inv.r10      = res_reg[3];
        inv.r11      = res_reg[4];
        inv.r12      = res_reg[5];
        inv.r20      = res_reg[6];
        inv.r21      = res_reg[7];
        inv.r22      = res_reg[8];
        inv.singular = sing_reg;
    end

endmodule

`default_nettype wire

FILE: design/m3i_checker.sv
// m3i_checker: port-level assertions for matrix3_inverse_core, bound to the top.
// Depends on m3i_pkg.
`default_nettype none

module m3i_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               mat_valid,
    input wire logic               mat_stall,
    input wire logic               inv_valid,
    input wire logic               inv_stall,
    input wire m3i_pkg::inv_word_t inv
);

    localparam int DEPTH = m3i_pkg::PIPE_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] occ_reg;
    logic             take_in;
    logic             take_out;

    assign take_in  = mat_valid && !mat_stall;
    assign take_out = inv_valid && !inv_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (take_in && !take_out)
        begin
            occ_reg <= occ_reg + 1'b1;
        end
        else if (take_out && !take_in)
        begin
            occ_reg <= occ_reg - 1'b1;
        end
    end

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid |-> occ_reg != '0)
        else $error("result word without a pending matrix");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("more words in flight than pipeline stages");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv.singular |->
            inv.r00 == '0 && inv.r01 == '0 && inv.r02 == '0 &&
            inv.r10 == '0 && inv.r11 == '0 && inv.r12 == '0 &&
            inv.r20 == '0 && inv.r21 == '0 && inv.r22 == '0)
        else $error("singular word with nonzero entries");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_stall |=> inv_valid && $stable(inv))
        else $error("stalled result word changed");

endmodule

bind matrix3_inverse_core m3i_checker u_m3i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_valid (mat_valid),
    .mat_stall (mat_stall),
    .inv_valid (inv_valid),
    .inv_stall (inv_stall),
    .inv       (inv)
);

`default_nettype wire
